[sv/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dfa_pkg.sv]
`default_nettype none
package dfa_pkg;

    localparam int IN_W     = 144;
    localparam int OUT_W    = 72;
    localparam int WIDE_W   = 128;
    localparam int DEN_W    = 64;
    localparam int DIV_CW   = $clog2(WIDE_W);

    // Operation codes
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_MUL = 3'd1;
    localparam logic [2:0] MODE_DIV = 3'd2;
    localparam logic [2:0] MODE_CMP = 3'd3;
    localparam logic [2:0] MODE_INT = 3'd4;
    localparam logic [2:0] MODE_NEG = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_NEGATIVE  = 3'd4;
    localparam logic [2:0] ST_SATURATED = 3'd5;

    localparam logic signed [10:0] EXP_MIN  = -11'sd96;
    localparam logic signed [10:0] EXP_MAX  = 11'sd80;
    localparam logic signed [10:0] EXP_BIAS = 11'sd97;
    localparam logic signed [10:0] DIV_SCALE_EXP = 11'sd17;
    localparam logic [63:0] MANT_MAX      = 64'd9_999_999_999_999_999;
    localparam logic [62:0] INT_LIMIT     = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_LIM_DIV10 = 64'd922_337_203_685_477_580;
    localparam logic [62:0] SIGN_BIT      = 63'h4000_0000_0000_0000;
    localparam logic [5:0]  MANT_DIGITS   = 6'd16;
    localparam logic [5:0]  ALIGN_LIMIT   = 6'd20;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_PREP,
        S_ADD_ALIGN,
        S_ADD_SUM,
        S_MUL_WAIT,
        S_DIV_MUL,
        S_DIV_DIV,
        S_CMP_NORM,
        S_CMP_DONE,
        S_INT_DOWN,
        S_INT_UP,
        S_NORM_CHK,
        S_NORM_UP,
        S_NORM_CNT,
        S_NORM_DOWN,
        S_NORM_PACK,
        S_FIN
    } dfa_state_t;

    // Powers of ten up to 10^34
    function automatic logic [127:0] pow10(input logic [5:0] k);
        logic [127:0] r;
        case (k)
            6'd0:  r = 128'd1;
            6'd1:  r = 128'd10;
            6'd2:  r = 128'd100;
            6'd3:  r = 128'd1_000;
            6'd4:  r = 128'd10_000;
            6'd5:  r = 128'd100_000;
            6'd6:  r = 128'd1_000_000;
            6'd7:  r = 128'd10_000_000;
            6'd8:  r = 128'd100_000_000;
            6'd9:  r = 128'd1_000_000_000;
            6'd10: r = 128'd10_000_000_000;
            6'd11: r = 128'd100_000_000_000;
            6'd12: r = 128'd1_000_000_000_000;
            6'd13: r = 128'd10_000_000_000_000;
            6'd14: r = 128'd100_000_000_000_000;
            6'd15: r = 128'd1_000_000_000_000_000;
            6'd16: r = 128'd10_000_000_000_000_000;
            6'd17: r = 128'd100_000_000_000_000_000;
            6'd18: r = 128'd1_000_000_000_000_000_000;
            6'd19: r = 128'd10_000_000_000_000_000_000;
            6'd20: r = 128'd100_000_000_000_000_000_000;
            6'd21: r = 128'd1_000_000_000_000_000_000_000;
            6'd22: r = 128'd10_000_000_000_000_000_000_000;
            6'd23: r = 128'd100_000_000_000_000_000_000_000;
            6'd24: r = 128'd1_000_000_000_000_000_000_000_000;
            6'd25: r = 128'd10_000_000_000_000_000_000_000_000;
            6'd26: r = 128'd100_000_000_000_000_000_000_000_000;
            6'd27: r = 128'd1_000_000_000_000_000_000_000_000_000;
            6'd28: r = 128'd10_000_000_000_000_000_000_000_000_000;
            6'd29: r = 128'd100_000_000_000_000_000_000_000_000_000;
            6'd30: r = 128'd1_000_000_000_000_000_000_000_000_000_000;
            6'd31: r = 128'd10_000_000_000_000_000_000_000_000_000_000;
            6'd32: r = 128'd100_000_000_000_000_000_000_000_000_000_000;
            6'd33: r = 128'd1_000_000_000_000_000_000_000_000_000_000_000;
            6'd34: r = 128'd10_000_000_000_000_000_000_000_000_000_000_000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/dfa_mul.sv]
`default_nettype none
// 64x64 multiplier built from four 32x32 partial products, one per cycle.
module dfa_mul
    import dfa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      product
);

    logic [63:0]  a_reg, b_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   step_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  a_half, b_half;
    logic [63:0]  part;
    logic [127:0] part_sh;

    // Select the halves for this step and form one partial product
    always_comb
    begin
        a_half = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = step_reg[1] ? b_reg[63:32] : b_reg[31:0];
        part   = 64'(a_half) * 64'(b_half);
        case (sh_reg)
            2'd0:    part_sh = {64'b0, prod_reg};
            2'd1:    part_sh = {32'b0, prod_reg, 32'b0};
            2'd2:    part_sh = {prod_reg, 64'b0};
            default: part_sh = '0;
        endcase
        acc_next = (step_reg != 3'd0) ? acc_reg + part_sh : acc_reg;
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands, partial product and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= part;
            sh_reg   <= 2'(step_reg[0]) + 2'(step_reg[1]);
            acc_reg  <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

[sv/dfa_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module dfa_div
    import dfa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [WIDE_W-1:0]   num,
    input  wire logic [DEN_W-1:0]    den,
    output logic                     done,
    output logic [WIDE_W-1:0]        quot
);

    logic [WIDE_W-1:0] num_reg;
    logic [DEN_W-1:0]  den_reg, rem_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DEN_W:0]    shifted, diff;
    logic              ge;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, num_reg[WIDE_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '1;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the quotient in where the dividend leaves
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[WIDE_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule
`default_nettype wire

[sv/decimal_float_arith_unit.sv]
`default_nettype none
`include "assert_macros.svh"
// Channel | Dir | Fields
// s_*     | in  | tdata: mode, operand_a, operand_b, compare_flags, frac_places,
//         |     |        allow_magnitude (lowest bits first)
// m_*     | out | tdata: result_value, status (lowest bits first)
//
// One item at a time: s_tready is high only while the sequencer is idle.
// Negate, compare on signs and error cases go from dispatch straight to the finish
// state; multiply waits on the multiplier and then normalizes. The restoring divider
// sets the long cases: add alignment, divide, scaling down for the integer mode and
// normalizing a wide value each use it. A result waits in the output register
// while the next item is taken. Reset clears the sequencer and the output valid.
module decimal_float_arith_unit
    import dfa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // mode[2:0], operand_a[65:3], operand_b[128:66], compare_flags[131:129],
    // frac_places[136:132], allow_magnitude[137], zero pad
    input  wire logic [IN_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // result_value[62:0], status[65:63], zero pad
    output logic [OUT_W-1:0]        m_tdata
);

    dfa_state_t state_reg, state_next;

    logic [2:0]   mode_reg, flags_reg;
    logic [62:0]  a_reg, b_reg;
    logic [4:0]   places_reg;
    logic         allow_reg;
    logic [127:0] w_reg, w_next;
    logic signed [10:0] e_reg, e_next, e2_reg, e2_next;
    logic         neg_reg, neg_next, sneg_reg, sneg_next;
    logic [63:0]  xa_reg, xa_next, xb_reg, xb_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [62:0]  val_reg, val_next, out_val_reg;
    logic [2:0]   st_reg, st_next, out_st_reg;
    logic         out_valid_reg, out_valid_next;
    logic         out_load;

    logic         mul_start, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_prod;
    logic         div_start, div_done;
    logic [127:0] div_num, div_quot;
    logic [63:0]  div_den;

    // Unpacked operands
    logic [53:0]  am, bm;
    logic signed [10:0] ae, be, t, negt, diff;
    logic         an, bn, az, bz;
    logic signed [1:0] sa, sb;
    logic         in_xfer;
    logic         small_w, wide_w, cnt_more, xa_low, xb_low;
    logic [7:0]   drop;
    logic         lt_mag, gt_mag, lt, gt, eq, truth;
    logic         int_done_ovf;

    assign in_xfer = s_tvalid && s_tready;

    always_comb
    begin
        am   = a_reg[53:0];
        bm   = b_reg[53:0];
        ae   = $signed({3'b000, a_reg[61:54]}) - EXP_BIAS;
        be   = $signed({3'b000, b_reg[61:54]}) - EXP_BIAS;
        an   = ~a_reg[62];
        bn   = ~b_reg[62];
        az   = (am == '0);
        bz   = (bm == '0);
        sa   = az ? 2'sd0 : (an ? -2'sd1 : 2'sd1);
        sb   = bz ? 2'sd0 : (bn ? -2'sd1 : 2'sd1);
        t    = ae + $signed({6'b0, places_reg});
        negt = -t;
        diff = e_reg - e2_reg;
        small_w  = (w_reg < pow10(6'd15));
        wide_w   = (w_reg > {64'b0, MANT_MAX});
        cnt_more = (w_reg >= pow10(cnt_reg[5:0] + 6'd1));
        drop     = cnt_reg - 8'd15;
        xa_low   = (xa_reg < 64'(pow10(MANT_DIGITS)));
        xb_low   = (xb_reg < 64'(pow10(MANT_DIGITS)));
        lt_mag   = (e_reg < e2_reg) || ((e_reg == e2_reg) && (xa_reg < xb_reg));
        gt_mag   = (e_reg > e2_reg) || ((e_reg == e2_reg) && (xa_reg > xb_reg));
        lt       = neg_reg ? gt_mag : lt_mag;
        gt       = neg_reg ? lt_mag : gt_mag;
        eq       = !lt_mag && !gt_mag;
        truth    = (flags_reg[0] && eq) || (flags_reg[1] && lt) || (flags_reg[2] && gt);
        int_done_ovf = (xa_reg > INT_LIM_DIV10);
        out_load = (state_reg == S_FIN) && (!out_valid_reg || m_tready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_xfer)
                    state_next = S_DISPATCH;
            S_DISPATCH:
                case (mode_reg)
                    MODE_ADD: state_next = (az || bz) ? S_NORM_CHK : S_ADD_PREP;
                    MODE_MUL: state_next = (az || bz) ? S_FIN : S_MUL_WAIT;
                    MODE_DIV: state_next = (az || bz) ? S_FIN : S_DIV_MUL;
                    MODE_CMP:
                        if (flags_reg == 3'd0 || flags_reg == 3'd7 || sa != sb || sa == 2'sd0)
                            state_next = S_FIN;
                        else
                            state_next = S_CMP_NORM;
                    MODE_INT:
                        if (places_reg > 5'd15 || az || (an && !allow_reg))
                            state_next = S_FIN;
                        else if (t < 0)
                            state_next = (t <= -11'sd20) ? S_FIN : S_INT_DOWN;
                        else
                            state_next = S_INT_UP;
                    default: state_next = S_FIN;
                endcase
            S_ADD_PREP:
                state_next = (diff >= $signed({5'b0, ALIGN_LIMIT}) || diff == 0) ?
                             S_ADD_SUM : S_ADD_ALIGN;
            S_ADD_ALIGN:
                if (div_done)
                    state_next = S_ADD_SUM;
            S_ADD_SUM:
                state_next = S_NORM_CHK;
            S_MUL_WAIT:
                if (mul_done)
                    state_next = S_NORM_CHK;
            S_DIV_MUL:
                if (mul_done)
                    state_next = S_DIV_DIV;
            S_DIV_DIV:
                if (div_done)
                    state_next = S_NORM_CHK;
            S_CMP_NORM:
                if (!xa_low && !xb_low)
                    state_next = S_CMP_DONE;
            S_CMP_DONE:
                state_next = S_FIN;
            S_INT_DOWN:
                if (div_done)
                    state_next = S_FIN;
            S_INT_UP:
                if (cnt_reg == '0 || int_done_ovf)
                    state_next = S_FIN;
            S_NORM_CHK:
                if (w_reg == '0)
                    state_next = S_FIN;
                else if (small_w)
                    state_next = S_NORM_UP;
                else if (wide_w)
                    state_next = S_NORM_CNT;
                else
                    state_next = S_NORM_PACK;
            S_NORM_UP:
                if (!small_w)
                    state_next = S_NORM_PACK;
            S_NORM_CNT:
                if (!cnt_more)
                    state_next = S_NORM_DOWN;
            S_NORM_DOWN:
                if (div_done)
                    state_next = S_NORM_PACK;
            S_NORM_PACK:
                state_next = S_FIN;
            S_FIN:
                if (!out_valid_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and shared unit starts
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        mul_start = 1'b0;
        mul_a     = {10'b0, am};
        mul_b     = {10'b0, bm};
        div_start = 1'b0;
        div_num   = {64'b0, xb_reg};
        div_den   = 64'(pow10(diff[5:0]));
        case (state_reg)
            S_DISPATCH:
            begin
                if (mode_reg == MODE_MUL && !az && !bz)
                    mul_start = 1'b1;
                if (mode_reg == MODE_DIV && !az && !bz)
                begin
                    mul_start = 1'b1;
                    mul_b     = 64'(pow10(6'd17));
                end
                if (mode_reg == MODE_INT && places_reg <= 5'd15 && !az &&
                    !(an && !allow_reg) && t < 0 && t > -11'sd20)
                begin
                    div_start = 1'b1;
                    div_num   = {74'b0, am};
                    div_den   = 64'(pow10(negt[5:0]));
                end
            end
            S_ADD_PREP:
                div_start = !(diff >= $signed({5'b0, ALIGN_LIMIT}) || diff == 0);
            S_DIV_MUL:
            begin
                div_start = mul_done;
                div_num   = mul_prod;
                div_den   = {10'b0, bm};
            end
            S_NORM_CNT:
            begin
                div_start = !cnt_more;
                div_num   = w_reg;
                div_den   = 64'(pow10(drop[5:0]));
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        w_next    = w_reg;
        e_next    = e_reg;
        e2_next   = e2_reg;
        neg_next  = neg_reg;
        sneg_next = sneg_reg;
        xa_next   = xa_reg;
        xb_next   = xb_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        st_next   = st_reg;
        case (state_reg)
            S_DISPATCH:
            begin
                val_next = '0;
                st_next  = ST_OK;
                case (mode_reg)
                    MODE_ADD:
                        if (az)
                        begin
                            w_next   = {74'b0, bm};
                            e_next   = be;
                            neg_next = bn;
                        end
                        else if (bz)
                        begin
                            w_next   = {74'b0, am};
                            e_next   = ae;
                            neg_next = an;
                        end
                        else if (ae < be)
                        begin
                            xa_next   = {10'b0, bm};
                            xb_next   = {10'b0, am};
                            e_next    = be;
                            e2_next   = ae;
                            neg_next  = bn;
                            sneg_next = an;
                        end
                        else
                        begin
                            xa_next   = {10'b0, am};
                            xb_next   = {10'b0, bm};
                            e_next    = ae;
                            e2_next   = be;
                            neg_next  = an;
                            sneg_next = bn;
                        end
                    MODE_MUL:
                    begin
                        e_next   = ae + be;
                        neg_next = an ^ bn;
                    end
                    MODE_DIV:
                    begin
                        e_next   = ae - be - DIV_SCALE_EXP;
                        neg_next = an ^ bn;
                        if (bz)
                            st_next = ST_DIVZERO;
                    end
                    MODE_CMP:
                    begin
                        xa_next  = {10'b0, am};
                        xb_next  = {10'b0, bm};
                        e_next   = ae;
                        e2_next  = be;
                        neg_next = an;
                        if (flags_reg == 3'd0 || flags_reg == 3'd7)
                            st_next = ST_INVALID;
                        else if (sa != sb)
                            val_next = {62'b0, (sa < sb) ? flags_reg[1] : flags_reg[2]};
                        else if (sa == 2'sd0)
                            val_next = {62'b0, flags_reg[0]};
                    end
                    MODE_INT:
                    begin
                        xa_next  = {10'b0, am};
                        cnt_next = t[7:0];
                        if (places_reg > 5'd15)
                            st_next = ST_INVALID;
                        else if (!az && an && !allow_reg)
                            st_next = ST_NEGATIVE;
                    end
                    MODE_NEG:
                        val_next = az ? '0 : (a_reg ^ SIGN_BIT);
                    default:
                        st_next = ST_INVALID;
                endcase
            end
            S_ADD_PREP:
                if (diff >= $signed({5'b0, ALIGN_LIMIT}))
                    xb_next = '0;
            S_ADD_ALIGN:
                if (div_done)
                    xb_next = div_quot[63:0];
            S_ADD_SUM:
                if (neg_reg == sneg_reg)
                    w_next = {64'b0, xa_reg + xb_reg};
                else if (xa_reg >= xb_reg)
                    w_next = {64'b0, xa_reg - xb_reg};
                else
                begin
                    w_next   = {64'b0, xb_reg - xa_reg};
                    neg_next = sneg_reg;
                end
            S_MUL_WAIT:
                if (mul_done)
                    w_next = mul_prod;
            S_DIV_DIV:
                if (div_done)
                    w_next = div_quot;
            S_CMP_NORM:
            begin
                if (xa_low)
                begin
                    xa_next = xa_reg * 64'd10;
                    e_next  = e_reg - 11'sd1;
                end
                if (xb_low)
                begin
                    xb_next = xb_reg * 64'd10;
                    e2_next = e2_reg - 11'sd1;
                end
            end
            S_CMP_DONE:
                val_next = {62'b0, truth};
            S_INT_DOWN:
                if (div_done)
                    val_next = div_quot[62:0];
            S_INT_UP:
                if (cnt_reg == '0)
                    val_next = xa_reg[62:0];
                else if (int_done_ovf)
                begin
                    val_next = INT_LIMIT;
                    st_next  = ST_SATURATED;
                end
                else
                begin
                    xa_next  = xa_reg * 64'd10;
                    cnt_next = cnt_reg - 8'd1;
                end
            S_NORM_CHK:
                cnt_next = 8'(MANT_DIGITS);
            S_NORM_UP:
                if (small_w)
                begin
                    w_next = {64'b0, w_reg[63:0] * 64'd10};
                    e_next = e_reg - 11'sd1;
                end
            S_NORM_CNT:
                if (cnt_more)
                    cnt_next = cnt_reg + 8'd1;
                else
                    e_next = e_reg + $signed({5'b0, drop[5:0]});
            S_NORM_DOWN:
                if (div_done)
                    w_next = div_quot;
            S_NORM_PACK:
                if (e_reg < EXP_MIN || e_reg > EXP_MAX)
                    st_next = ST_RANGE;
                else
                    val_next = {~neg_reg, 8'(e_reg + EXP_BIAS), w_reg[53:0]};
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the item and hold working values
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg   <= s_tdata[2:0];
            a_reg      <= s_tdata[65:3];
            b_reg      <= s_tdata[128:66];
            flags_reg  <= s_tdata[131:129];
            places_reg <= s_tdata[136:132];
            allow_reg  <= s_tdata[137];
        end
        w_reg    <= w_next;
        e_reg    <= e_next;
        e2_reg   <= e2_next;
        neg_reg  <= neg_next;
        sneg_reg <= sneg_next;
        xa_reg   <= xa_next;
        xb_reg   <= xb_next;
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        st_reg   <= st_next;
        if (out_load)
        begin
            out_val_reg <= (st_reg == ST_OK || st_reg == ST_SATURATED) ? val_reg : '0;
            out_st_reg  <= st_reg;
        end
    end

    dfa_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    dfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_st_reg, out_val_reg};

    // Checks
    `DFA_ASSERT(a_one_item, in_xfer |=> !s_tready, "input taken while busy")
    `DFA_ASSERT(a_err_zero, m_tvalid && m_tdata[65:63] != ST_OK && m_tdata[65:63] != ST_SATURATED |-> m_tdata[62:0] == '0, "error result not zero")
    `DFA_ASSERT(a_sat_value, m_tvalid && m_tdata[65:63] == ST_SATURATED |-> m_tdata[62:0] == INT_LIMIT, "saturated value wrong")
    `DFA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "output valid in reset")

endmodule
`default_nettype wire
